// ===== hw/rtl/bhs_pkg.sv =====
// Shared constants, opcode codes, severities and types for the bytecode hazard scanner.
// Used by the report stage, the scanner top level and the testbench; depends on nothing.
`default_nettype none

package bhs_pkg;

    // Default size of the jump-destination store, in program bytes.
    localparam int MAX_CODE_BYTES_DFLT = 32768;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPENSIVE_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_JUMP_LIMIT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_DIVISOR   = 2'd2;
    localparam int CFG_DATA_W = 16;

    // Register values after reset.
    localparam logic [15:0] EXPENSIVE_LIMIT_RST = 16'd50;
    localparam logic [15:0] JUMP_LIMIT_RST      = 16'd5;
    localparam logic [7:0]  RATIO_DIVISOR_RST   = 8'd10;

    // Opcodes.
    localparam logic [7:0] OP_SSTORE       = 8'h55;
    localparam logic [7:0] OP_JUMP         = 8'h56;
    localparam logic [7:0] OP_JUMPI        = 8'h57;
    localparam logic [7:0] OP_GAS          = 8'h5a;
    localparam logic [7:0] OP_JUMPDEST     = 8'h5b;
    localparam logic [7:0] OP_PUSH_BASE    = 8'h5f;
    localparam logic [7:0] OP_PUSH1        = 8'h60;
    localparam logic [7:0] OP_PUSH32       = 8'h7f;
    localparam logic [7:0] OP_LOG0         = 8'ha0;
    localparam logic [7:0] OP_LOG4         = 8'ha4;
    localparam logic [7:0] OP_CREATE       = 8'hf0;
    localparam logic [7:0] OP_CALL         = 8'hf1;
    localparam logic [7:0] OP_CALLCODE     = 8'hf2;
    localparam logic [7:0] OP_DELEGATECALL = 8'hf4;
    localparam logic [7:0] OP_CREATE2      = 8'hf5;
    localparam logic [7:0] OP_STATICCALL   = 8'hfa;
    localparam logic [7:0] OP_ORIGIN       = 8'h32;
    localparam logic [7:0] OP_SELFDESTRUCT = 8'hff;

    // Severities in tenths.
    localparam logic [3:0] SEV_FF    = 4'd9;
    localparam logic [3:0] SEV_F1    = 4'd7;
    localparam logic [3:0] SEV_F4    = 4'd6;
    localparam logic [3:0] SEV_32    = 4'd5;
    localparam logic [3:0] SEV_56    = 4'd8;
    localparam logic [3:0] SEV_INF   = 4'd9;
    localparam logic [3:0] SEV_RES   = 4'd8;
    localparam logic [3:0] SEV_REENT = 4'd7;
    localparam logic [3:0] SEV_UNB   = 4'd6;
    localparam logic [3:0] MALICIOUS_TENTHS = 4'd9;

    // Width of the push byte counter, and the counter ceiling.
    localparam int PUSH_LEFT_W = 6;
    localparam logic [15:0] COUNT_MAX = 16'hffff;

    // Findings latched over one program.
    typedef struct packed {
        logic too_long;
        logic unb;
        logic reent;
        logic inf;
        logic b56;
        logic b32;
        logic f4;
        logic f1;
        logic ff;
    } find_t;

    // Costly-op test: counted in the totals of the costly-op ratio.
    function automatic logic is_costly(input logic [7:0] b);
        is_costly = (b == OP_SSTORE) || (b == OP_CREATE) || (b == OP_CREATE2) ||
                    (b == OP_CALL) || (b == OP_CALLCODE) || (b == OP_DELEGATECALL) ||
                    (b == OP_STATICCALL) || ((b >= OP_LOG0) && (b <= OP_LOG4));
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bhs_if.sv =====
// Valid/ready channel interfaces for program bytes and for hazard reports.
// Depends on nothing; used by the scanner top level and the report stage.
`default_nettype none

interface bhs_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       last;

    modport source (output valid, output code_byte, output last, input ready);
    modport sink   (input valid, input code_byte, input last, output ready);
endinterface

interface bhs_report_if;
    logic       valid;
    logic       ready;
    logic [3:0] risk_tenths;
    logic       is_malicious;
    logic       has_selfdestruct;
    logic       has_infinite_loop;
    logic       has_resource_exhaustion;
    logic       has_reentrancy;
    logic       has_unbounded_loop;
    logic [3:0] detected_count;
    logic       code_too_long;

    modport source (output valid, output risk_tenths, output is_malicious,
                    output has_selfdestruct, output has_infinite_loop,
                    output has_resource_exhaustion, output has_reentrancy,
                    output has_unbounded_loop, output detected_count,
                    output code_too_long, input ready);
    modport sink   (input valid, input risk_tenths, input is_malicious,
                    input has_selfdestruct, input has_infinite_loop,
                    input has_resource_exhaustion, input has_reentrancy,
                    input has_unbounded_loop, input detected_count,
                    input code_too_long, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bhs_jd_map.sv =====
// Jump-destination bit map: one write port, one read port, registered read data.
// Depends on nothing; instantiated by bytecode_hazard_scanner.
`default_nettype none

module bhs_jd_map #(
    parameter int DEPTH  = 32768,
    parameter int ADDR_W = 15
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic              wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic                   rd_data
);

    logic mem [0:DEPTH-1];
    logic rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; a write to the same entry in the same cycle is passed through.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/bhs_report.sv =====
// Report stage: holds the totals of a finished program, scores them and presents the item.
// Depends on bhs_pkg and bhs_if; instantiated by bytecode_hazard_scanner.
`default_nettype none

module bhs_report #(
    parameter int POS_W = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             snap_load,
    output logic                  snap_ready,
    input  wire bhs_pkg::find_t   snap_find,
    input  wire logic [15:0]      snap_costly,
    input  wire logic [15:0]      snap_jumps,
    input  wire logic [POS_W-1:0] snap_length,
    input  wire logic [15:0]      expensive_limit,
    input  wire logic [15:0]      jump_limit,
    input  wire logic [7:0]       ratio_divisor,
    bhs_report_if.source          report
);

    localparam int PROD_W = 24;
    localparam int CMP_W  = (POS_W > PROD_W) ? POS_W : PROD_W;

    logic                 s1_valid_reg;
    bhs_pkg::find_t       s1_find_reg;
    logic [15:0]          s1_costly_reg;
    logic [15:0]          s1_jumps_reg;
    logic [POS_W-1:0]     s1_length_reg;
    logic                 s1_adv;

    logic                 out_valid_reg;
    logic [3:0]           out_risk_reg;
    logic                 out_mal_reg;
    logic [3:0]           out_count_reg;
    logic                 out_res_reg;
    bhs_pkg::find_t       out_find_reg;

    logic [PROD_W-1:0]    prod;
    logic                 res;
    logic [3:0]           risk;
    logic [3:0]           count;

    // The held totals move on when the output register is empty or being taken.
    assign s1_adv     = s1_valid_reg && (!out_valid_reg || report.ready);
    assign snap_ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (snap_load)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_load)
        begin
            s1_find_reg   <= snap_find;
            s1_costly_reg <= snap_costly;
            s1_jumps_reg  <= snap_jumps;
            s1_length_reg <= snap_length;
        end
    end

    // Resource test and the score over all findings.
    always_comb
    begin
        prod = PROD_W'(s1_costly_reg) * PROD_W'(ratio_divisor);
        res  = ((CMP_W'(prod) > CMP_W'(s1_length_reg)) && (s1_jumps_reg > jump_limit)) ||
               (s1_costly_reg > expensive_limit);
        risk  = 4'd0;
        count = 4'd0;
        if (s1_find_reg.ff)
        begin
            count = count + 4'd1;
            if (risk < bhs_pkg::SEV_FF) risk = bhs_pkg::SEV_FF;
        end
        if (s1_find_reg.f1)
        begin
            count = count + 4'd1;
            if (risk < bhs_pkg::SEV_F1) risk = bhs_pkg::SEV_F1;
        end
        if (s1_find_reg.f4)
        begin
            count = count + 4'd1;
            if (risk < bhs_pkg::SEV_F4) risk = bhs_pkg::SEV_F4;
        end
        if (s1_find_reg.b32)
        begin
            count = count + 4'd1;
            if (risk < bhs_pkg::SEV_32) risk = bhs_pkg::SEV_32;
        end
        if (s1_find_reg.b56)
        begin
            count = count + 4'd1;
            if (risk < bhs_pkg::SEV_56) risk = bhs_pkg::SEV_56;
        end
        if (s1_find_reg.inf)
        begin
            count = count + 4'd1;
            if (risk < bhs_pkg::SEV_INF) risk = bhs_pkg::SEV_INF;
        end
        if (s1_find_reg.reent)
        begin
            count = count + 4'd1;
            if (risk < bhs_pkg::SEV_REENT) risk = bhs_pkg::SEV_REENT;
        end
        if (s1_find_reg.unb)
        begin
            count = count + 4'd1;
            if (risk < bhs_pkg::SEV_UNB) risk = bhs_pkg::SEV_UNB;
        end
        if (res)
        begin
            count = count + 4'd1;
            if (risk < bhs_pkg::SEV_RES) risk = bhs_pkg::SEV_RES;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (report.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_risk_reg  <= risk;
            out_mal_reg   <= (risk >= bhs_pkg::MALICIOUS_TENTHS);
            out_count_reg <= count;
            out_res_reg   <= res;
            out_find_reg  <= s1_find_reg;
        end
    end

    assign report.valid                   = out_valid_reg;
    assign report.risk_tenths             = out_risk_reg;
    assign report.is_malicious            = out_mal_reg;
    assign report.has_selfdestruct        = out_find_reg.ff;
    assign report.has_infinite_loop       = out_find_reg.inf;
    assign report.has_resource_exhaustion = out_res_reg;
    assign report.has_reentrancy          = out_find_reg.reent;
    assign report.has_unbounded_loop      = out_find_reg.unb;
    assign report.detected_count          = out_count_reg;
    assign report.code_too_long           = out_find_reg.too_long;

endmodule

`default_nettype wire

// ===== hw/rtl/bytecode_hazard_scanner.sv =====
// Top level of the bytecode hazard scanner: byte scan, configuration registers, assertions.
// Depends on bhs_pkg, bhs_if, bhs_jd_map and bhs_report.
`default_nettype none

// The scanner takes one program byte per clock cycle, with no gaps between programs,
// and gives one report item per program by way of the report stage. Each byte inside
// the store makes one write to the jump-destination map (the byte's own position, set
// for a jump destination and cleared otherwise), and the last byte of a push immediate
// makes one read at the pushed target; that map, with one write port and one read
// port, sets the rate of one byte per cycle. Because every position below the current
// one is rewritten in the current program before it can be read, the map needs no
// clearing pass after reset or between programs. The input stalls only while a
// finished report is held in both the report stage and the output register.

module bytecode_hazard_scanner #(
    parameter int MAX_CODE_BYTES = bhs_pkg::MAX_CODE_BYTES_DFLT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    bhs_byte_if.sink                          code,
    bhs_report_if.source                      report,
    input  wire logic                         cfg_we,
    input  wire logic [bhs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bhs_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int ADDR_W = $clog2(MAX_CODE_BYTES);
    localparam int POS_W  = $clog2(MAX_CODE_BYTES + 1);
    localparam int TGT_W  = ADDR_W + 8;
    localparam int LEFT_W = bhs_pkg::PUSH_LEFT_W;

    // Configuration registers.
    logic [15:0] expensive_limit_reg;
    logic [15:0] jump_limit_reg;
    logic [7:0]  ratio_divisor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expensive_limit_reg <= bhs_pkg::EXPENSIVE_LIMIT_RST;
            jump_limit_reg      <= bhs_pkg::JUMP_LIMIT_RST;
            ratio_divisor_reg   <= bhs_pkg::RATIO_DIVISOR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bhs_pkg::CFG_EXPENSIVE_LIMIT: expensive_limit_reg <= cfg_data;
                bhs_pkg::CFG_JUMP_LIMIT:      jump_limit_reg      <= cfg_data;
                bhs_pkg::CFG_RATIO_DIVISOR:   ratio_divisor_reg   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Scan state.
    logic [POS_W-1:0]  position_reg,  position_next;
    logic [LEFT_W-1:0] push_left_reg, push_left_next;
    logic [ADDR_W-1:0] target_reg,    target_next;
    logic              tgt_ovf_reg,   tgt_ovf_next;
    logic              just_ended_reg, just_ended_next;
    logic [POS_W-1:0]  gas_pos_reg,   gas_pos_next;
    logic              gas_seen_reg,  gas_seen_next;
    logic              call_seen_reg, call_seen_next;
    logic [15:0]       costly_reg,    costly_next;
    logic [15:0]       jumps_reg,     jumps_next;
    bhs_pkg::find_t    find_reg,      find_next;

    logic              accept;
    logic              snap_ready;
    logic [7:0]        b;
    logic              is_jump;
    logic [TGT_W-1:0]  tgt_full;
    logic              in_range;
    logic              map_wr_en;
    logic              map_wr_data;
    logic              map_rd_en;
    logic              map_rd_data;

    assign code.ready = snap_ready;
    assign accept     = code.valid && snap_ready;
    assign b          = code.code_byte;
    assign is_jump    = (b == bhs_pkg::OP_JUMP) || (b == bhs_pkg::OP_JUMPI);
    assign in_range   = (position_reg < POS_W'(MAX_CODE_BYTES));
    assign tgt_full   = {target_reg, b};

    // Next scan state for an accepted byte.
    always_comb
    begin
        position_next   = position_reg;
        push_left_next  = push_left_reg;
        target_next     = target_reg;
        tgt_ovf_next    = tgt_ovf_reg;
        just_ended_next = just_ended_reg;
        gas_pos_next    = gas_pos_reg;
        gas_seen_next   = gas_seen_reg;
        call_seen_next  = call_seen_reg;
        costly_next     = costly_reg;
        jumps_next      = jumps_reg;
        find_next       = find_reg;
        map_wr_data     = 1'b0;
        map_rd_en       = 1'b0;

        if (!in_range) find_next.too_long = 1'b1;

        // Single-byte patterns, over every byte.
        if (b == bhs_pkg::OP_SELFDESTRUCT) find_next.ff  = 1'b1;
        if (b == bhs_pkg::OP_CALL)         find_next.f1  = 1'b1;
        if (b == bhs_pkg::OP_DELEGATECALL) find_next.f4  = 1'b1;
        if (b == bhs_pkg::OP_ORIGIN)       find_next.b32 = 1'b1;
        if (b == bhs_pkg::OP_JUMP)         find_next.b56 = 1'b1;

        if (push_left_reg != '0)
        begin
            // Immediate data byte; the last one starts the map read at the target.
            if (!tgt_ovf_reg)
            begin
                target_next  = tgt_full[ADDR_W-1:0];
                tgt_ovf_next = (tgt_full >= TGT_W'(MAX_CODE_BYTES));
            end
            push_left_next  = push_left_reg - LEFT_W'(1);
            just_ended_next = (push_left_reg == LEFT_W'(1));
            map_rd_en       = (push_left_reg == LEFT_W'(1));
        end
        else
        begin
            // Push-then-jump back to a recorded destination.
            if (just_ended_reg && is_jump && !tgt_ovf_reg &&
                (POS_W'(target_reg) < position_reg) && map_rd_data)
            begin
                find_next.inf = 1'b1;
                if (!(gas_seen_reg && (gas_pos_reg >= POS_W'(target_reg))))
                begin
                    find_next.unb = 1'b1;
                end
            end
            just_ended_next = 1'b0;

            if (bhs_pkg::is_costly(b) && (costly_reg != bhs_pkg::COUNT_MAX))
            begin
                costly_next = costly_reg + 16'd1;
            end
            if (is_jump && (jumps_reg != bhs_pkg::COUNT_MAX))
            begin
                jumps_next = jumps_reg + 16'd1;
            end

            // Call then store inside one code block.
            if ((b == bhs_pkg::OP_CALL) || (b == bhs_pkg::OP_CALLCODE) ||
                (b == bhs_pkg::OP_DELEGATECALL))
            begin
                call_seen_next = 1'b1;
            end
            if (call_seen_reg && (b == bhs_pkg::OP_SSTORE)) find_next.reent = 1'b1;
            if (b == bhs_pkg::OP_JUMPDEST)
            begin
                call_seen_next = 1'b0;
                map_wr_data    = 1'b1;
            end

            if ((b >= bhs_pkg::OP_PUSH1) && (b <= bhs_pkg::OP_PUSH32))
            begin
                push_left_next = LEFT_W'(b - bhs_pkg::OP_PUSH_BASE);
                target_next    = '0;
                tgt_ovf_next   = 1'b0;
            end
        end

        if (b == bhs_pkg::OP_GAS)
        begin
            gas_seen_next = 1'b1;
            gas_pos_next  = position_reg;
        end

        if (in_range) position_next = position_reg + POS_W'(1);
    end

    assign map_wr_en = accept && in_range;

    // Scan registers; the byte marked last hands the totals on and starts a new program.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg   <= '0;
            push_left_reg  <= '0;
            target_reg     <= '0;
            tgt_ovf_reg    <= 1'b0;
            just_ended_reg <= 1'b0;
            gas_pos_reg    <= '0;
            gas_seen_reg   <= 1'b0;
            call_seen_reg  <= 1'b0;
            costly_reg     <= '0;
            jumps_reg      <= '0;
            find_reg       <= '0;
        end
        else if (accept)
        begin
            if (code.last)
            begin
                position_reg   <= '0;
                push_left_reg  <= '0;
                target_reg     <= '0;
                tgt_ovf_reg    <= 1'b0;
                just_ended_reg <= 1'b0;
                gas_pos_reg    <= '0;
                gas_seen_reg   <= 1'b0;
                call_seen_reg  <= 1'b0;
                costly_reg     <= '0;
                jumps_reg      <= '0;
                find_reg       <= '0;
            end
            else
            begin
                position_reg   <= position_next;
                push_left_reg  <= push_left_next;
                target_reg     <= target_next;
                tgt_ovf_reg    <= tgt_ovf_next;
                just_ended_reg <= just_ended_next;
                gas_pos_reg    <= gas_pos_next;
                gas_seen_reg   <= gas_seen_next;
                call_seen_reg  <= call_seen_next;
                costly_reg     <= costly_next;
                jumps_reg      <= jumps_next;
                find_reg       <= find_next;
            end
        end
    end

    // Jump-destination map.
    bhs_jd_map #(
        .DEPTH  (MAX_CODE_BYTES),
        .ADDR_W (ADDR_W)
    ) u_map (
        .clk     (clk),
        .wr_en   (map_wr_en),
        .wr_addr (position_reg[ADDR_W-1:0]),
        .wr_data (map_wr_data),
        .rd_en   (accept && map_rd_en),
        .rd_addr (target_next),
        .rd_data (map_rd_data)
    );

    // Scoring and output stage.
    bhs_report #(
        .POS_W (POS_W)
    ) u_report (
        .clk             (clk),
        .rst_n           (rst_n),
        .snap_load       (accept && code.last),
        .snap_ready      (snap_ready),
        .snap_find       (find_next),
        .snap_costly     (costly_next),
        .snap_jumps      (jumps_next),
        .snap_length     (position_next),
        .expensive_limit (expensive_limit_reg),
        .jump_limit      (jump_limit_reg),
        .ratio_divisor   (ratio_divisor_reg),
        .report          (report)
    );

`ifndef SYNTHESIS
    // The position counter saturates at the size of the store.
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        position_reg <= POS_W'(MAX_CODE_BYTES))
        else $error("position counter ran past the store size");

    // A push immediate is never longer than thirty-two bytes.
    a_push_bound: assert property (@(posedge clk) disable iff (!rst_n)
        push_left_reg <= LEFT_W'(32))
        else $error("push byte count out of range");

    // The byte marked last leaves the scan state cleared for the next program.
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && code.last) |=> (position_reg == '0) && (find_reg == '0))
        else $error("scan state not cleared after last byte");

    // A map read is only pending while the byte after a push is awaited.
    a_read_on_push_end: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && map_rd_en && !code.last) |=> just_ended_reg)
        else $error("map read issued without a finished push");
`endif

endmodule

`default_nettype wire

// ===== verif/bytecode_hazard_scanner_tb.sv =====
// Self-checking testbench for the bytecode hazard scanner: random and directed programs.
// Depends on bhs_pkg, the bhs_if channel interfaces and the bytecode_hazard_scanner top level.
`default_nettype none

module bytecode_hazard_scanner_tb;

    localparam int MAX_CODE    = bhs_pkg::MAX_CODE_BYTES_DFLT;
    localparam int HOLD_CYCLES = 300;

    localparam logic [7:0] CALL_OPS [3] = '{bhs_pkg::OP_CALL, bhs_pkg::OP_CALLCODE,
                                            bhs_pkg::OP_DELEGATECALL};
    localparam logic [7:0] SPAWN_OPS [3] = '{bhs_pkg::OP_CREATE, bhs_pkg::OP_CREATE2,
                                             bhs_pkg::OP_STATICCALL};
    localparam logic [7:0] RAW_OPS [3] = '{bhs_pkg::OP_SELFDESTRUCT, bhs_pkg::OP_ORIGIN,
                                           bhs_pkg::OP_JUMP};

    // One program byte waiting to be offered, with the idle cycles in front of it.
    typedef struct {
        logic [7:0] value;
        logic       last;
        int         gap;
    } pending_byte_t;

    // Report fields as the scanner should give them for one program.
    typedef struct {
        logic [3:0] risk;
        logic       malicious;
        logic       selfdestruct;
        logic       inf_loop;
        logic       exhaustion;
        logic       reentrancy;
        logic       unbounded;
        logic [3:0] found;
        logic       too_long;
    } hazard_report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b1;
    logic cfg_we;
    logic [bhs_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [bhs_pkg::CFG_DATA_W-1:0] cfg_data;

    bhs_byte_if   byte_ch ();
    bhs_report_if rpt_ch ();

    bytecode_hazard_scanner i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .code     (byte_ch),
        .report   (rpt_ch),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #1 clk = ~clk;

    pending_byte_t  program_bytes_q[$];
    hazard_report_t expected_reports_q[$];
    int errors = 0;
    int planned_bytes = 0;
    int gap_cap = 11;
    int stall_cap = 11;
    int holds_asked = 0;
    int holds_served = 0;

    // Limits as last written.
    int expensive_lim;
    int jump_lim;
    int ratio_div;

    // Scan state of the program in flight.
    int      scan_pos;
    int      push_left;
    int      push_tgt;
    bit      tgt_ovf;
    bit      push_done;
    bit      dest_map[int];
    int      gas_pos;
    bit      gas_seen;
    bit      call_open;
    int      costly_ops;
    int      jump_ops;
    bhs_pkg::find_t flags;

    function automatic bit costly_op(input logic [7:0] b);
        case (b)
            bhs_pkg::OP_SSTORE, bhs_pkg::OP_CREATE, bhs_pkg::OP_CREATE2, bhs_pkg::OP_CALL,
            bhs_pkg::OP_CALLCODE, bhs_pkg::OP_DELEGATECALL, bhs_pkg::OP_STATICCALL:
                return 1'b1;
            default:
                return (b >= bhs_pkg::OP_LOG0) && (b <= bhs_pkg::OP_LOG4);
        endcase
    endfunction

    task automatic start_program();
        scan_pos = 0;
        push_left = 0;
        push_tgt = 0;
        tgt_ovf = 1'b0;
        push_done = 1'b0;
        dest_map.delete();
        gas_pos = 0;
        gas_seen = 1'b0;
        call_open = 1'b0;
        costly_ops = 0;
        jump_ops = 0;
        flags = '0;
    endtask

    // Advance the scan by one accepted byte; at the last byte queue the report.
    task automatic scan_byte(input logic [7:0] b, input logic is_last);
        int             here;
        bit             exhausted;
        bit             hits[9];
        logic [3:0]     sev[9];
        hazard_report_t rep;
        here = scan_pos;
        if (here >= MAX_CODE)
            flags.too_long = 1'b1;
        if (b == bhs_pkg::OP_SELFDESTRUCT) flags.ff = 1'b1;
        if (b == bhs_pkg::OP_CALL) flags.f1 = 1'b1;
        if (b == bhs_pkg::OP_DELEGATECALL) flags.f4 = 1'b1;
        if (b == bhs_pkg::OP_ORIGIN) flags.b32 = 1'b1;
        if (b == bhs_pkg::OP_JUMP) flags.b56 = 1'b1;

        if (push_left != 0)
        begin
            // Immediate data byte, folded into the big-endian target.
            if (!tgt_ovf)
            begin
                push_tgt = (push_tgt << 8) | int'(b);
                if (push_tgt >= MAX_CODE)
                    tgt_ovf = 1'b1;
            end
            push_left--;
            push_done = (push_left == 0);
        end
        else
        begin
            // A jump right after a push that lands back on a destination is a loop.
            if (push_done && (b == bhs_pkg::OP_JUMP || b == bhs_pkg::OP_JUMPI) && !tgt_ovf &&
                push_tgt < here && dest_map.exists(push_tgt))
            begin
                flags.inf = 1'b1;
                if (!(gas_seen && gas_pos >= push_tgt))
                    flags.unb = 1'b1;
            end
            push_done = 1'b0;
            if (costly_op(b) && costly_ops < 65535)
                costly_ops++;
            if ((b == bhs_pkg::OP_JUMP || b == bhs_pkg::OP_JUMPI) && jump_ops < 65535)
                jump_ops++;
            if (b == bhs_pkg::OP_CALL || b == bhs_pkg::OP_CALLCODE ||
                b == bhs_pkg::OP_DELEGATECALL)
                call_open = 1'b1;
            if (call_open && b == bhs_pkg::OP_SSTORE)
                flags.reent = 1'b1;
            if (b == bhs_pkg::OP_JUMPDEST)
            begin
                call_open = 1'b0;
                if (here < MAX_CODE)
                    dest_map[here] = 1'b1;
            end
            if (b >= bhs_pkg::OP_PUSH1 && b <= bhs_pkg::OP_PUSH32)
            begin
                push_left = int'(b) - int'(bhs_pkg::OP_PUSH_BASE);
                push_tgt = 0;
                tgt_ovf = 1'b0;
            end
        end

        if (b == bhs_pkg::OP_GAS)
        begin
            gas_seen = 1'b1;
            gas_pos = here;
        end
        if (scan_pos < MAX_CODE)
            scan_pos++;

        if (is_last)
        begin
            exhausted = (costly_ops * ratio_div > scan_pos && jump_ops > jump_lim) ||
                        costly_ops > expensive_lim;
            hits = '{flags.ff, flags.f1, flags.f4, flags.b32, flags.b56, flags.inf,
                     flags.reent, flags.unb, exhausted};
            sev = '{bhs_pkg::SEV_FF, bhs_pkg::SEV_F1, bhs_pkg::SEV_F4, bhs_pkg::SEV_32,
                    bhs_pkg::SEV_56, bhs_pkg::SEV_INF, bhs_pkg::SEV_REENT, bhs_pkg::SEV_UNB,
                    bhs_pkg::SEV_RES};
            rep.risk = '0;
            rep.found = '0;
            for (int i = 0; i < 9; i++)
            begin
                if (hits[i])
                begin
                    rep.found++;
                    if (rep.risk < sev[i])
                        rep.risk = sev[i];
                end
            end
            rep.malicious = (rep.risk >= bhs_pkg::MALICIOUS_TENTHS);
            rep.selfdestruct = flags.ff;
            rep.inf_loop = flags.inf;
            rep.exhaustion = exhausted;
            rep.reentrancy = flags.reent;
            rep.unbounded = flags.unb;
            rep.too_long = flags.too_long;
            expected_reports_q.insert(expected_reports_q.size(), rep);
            start_program();
        end
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // Driver: offers queued program bytes, with the drawn idle cycles before each item.
    pending_byte_t next_byte;
    int gap_left = 0;
    bit gap_loaded = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_ch.valid <= 1'b0;
            byte_ch.code_byte <= '0;
            byte_ch.last <= 1'b0;
        end
        else
        begin
            if (byte_ch.valid && byte_ch.ready)
                scan_byte(byte_ch.code_byte, byte_ch.last);
            if (!byte_ch.valid || byte_ch.ready)
            begin
                if (program_bytes_q.size() != 0 && !gap_loaded)
                begin
                    gap_left = program_bytes_q[0].gap;
                    gap_loaded = 1'b1;
                end
                if (gap_loaded && gap_left == 0)
                begin
                    next_byte = program_bytes_q[0];
                    program_bytes_q.delete(0);
                    gap_loaded = 1'b0;
                    byte_ch.valid <= 1'b1;
                    byte_ch.code_byte <= next_byte.value;
                    byte_ch.last <= next_byte.last;
                end
                else
                begin
                    byte_ch.valid <= 1'b0;
                    if (gap_left != 0)
                        gap_left--;
                end
            end
        end
    end

    // Monitor: checks each report item and throttles ready.
    hazard_report_t want;
    int stall_left = 0;
    int hold_left = 0;
    bit took;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpt_ch.ready <= 1'b0;
        end
        else
        begin
            took = rpt_ch.valid && rpt_ch.ready;
            if (took)
            begin
                if (expected_reports_q.size() == 0)
                begin
                    $display("%0t: report item with none expected", $time);
                    errors++;
                end
                else
                begin
                    want = expected_reports_q[0];
                    expected_reports_q.delete(0);
                    check_field("code_too_long", want.too_long, rpt_ch.code_too_long);
                    check_field("risk_tenths", want.risk, rpt_ch.risk_tenths);
                    check_field("is_malicious", want.malicious, rpt_ch.is_malicious);
                    check_field("has_selfdestruct", want.selfdestruct,
                                rpt_ch.has_selfdestruct);
                    check_field("has_infinite_loop", want.inf_loop,
                                rpt_ch.has_infinite_loop);
                    check_field("has_resource_exhaustion", want.exhaustion,
                                rpt_ch.has_resource_exhaustion);
                    check_field("has_reentrancy", want.reentrancy, rpt_ch.has_reentrancy);
                    check_field("has_unbounded_loop", want.unbounded,
                                rpt_ch.has_unbounded_loop);
                    check_field("detected_count", want.found, rpt_ch.detected_count);
                end
            end

            if (holds_served != holds_asked)
            begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                rpt_ch.ready <= 1'b0;
            end
            else
            begin
                if (took)
                    stall_left = (stall_cap == 0) ? 0 : $urandom_range(0, stall_cap);
                if (stall_left != 0)
                begin
                    stall_left--;
                    rpt_ch.ready <= 1'b0;
                end
                else
                    rpt_ch.ready <= 1'b1;
            end
        end
    end

    // Queue one program, marking its final byte as last.
    task automatic queue_program_bytes(input logic [7:0] prog[$]);
        pending_byte_t item;
        for (int k = 0; k < prog.size(); k++)
        begin
            item.value = prog[k];
            item.last = (k == prog.size() - 1);
            item.gap = (gap_cap == 0) ? 0 : $urandom_range(0, gap_cap);
            program_bytes_q.insert(program_bytes_q.size(), item);
            planned_bytes++;
        end
    endtask

    // Build a mostly well-formed program: destinations, push-then-jump back to
    // them, calls, stores, costly ops, plus noise and an occasional cut-off end.
    task automatic queue_random_program(input int len_goal);
        logic [7:0] prog[$];
        int dests[$];
        int r;
        int n;
        int tgt;
        int cut;
        while (prog.size() < len_goal)
        begin
            r = $urandom_range(0, 99);
            if (r < 12)
            begin
                dests.insert(dests.size(), prog.size());
                prog.insert(prog.size(), bhs_pkg::OP_JUMPDEST);
            end
            else if (r < 20)
                prog.insert(prog.size(), bhs_pkg::OP_GAS);
            else if (r < 34)
            begin
                if (dests.size() != 0 && $urandom_range(0, 3) != 0)
                    tgt = dests[$urandom_range(0, dests.size() - 1)];
                else if ($urandom_range(0, 5) == 0)
                    tgt = $urandom_range(MAX_CODE, 24'hffffff);
                else
                    tgt = $urandom_range(0, prog.size() + 8);
                n = (tgt < 256) ? 1 : (tgt < 65536) ? 2 : 3;
                if ($urandom_range(0, 7) == 0)
                    n = 32;
                else
                    n = n + $urandom_range(0, 1);
                prog.insert(prog.size(), bhs_pkg::OP_PUSH_BASE + 8'(n));
                for (int k = n - 1; k >= 0; k--)
                    prog.insert(prog.size(), (k < 4) ? 8'(tgt >> (8 * k)) : 8'h00);
                prog.insert(prog.size(),
                            $urandom_range(0, 1) ? bhs_pkg::OP_JUMP : bhs_pkg::OP_JUMPI);
            end
            else if (r < 44)
                prog.insert(prog.size(), CALL_OPS[$urandom_range(0, 2)]);
            else if (r < 52)
                prog.insert(prog.size(), bhs_pkg::OP_SSTORE);
            else if (r < 58)
                prog.insert(prog.size(), SPAWN_OPS[$urandom_range(0, 2)]);
            else if (r < 62)
                prog.insert(prog.size(),
                            8'($urandom_range(bhs_pkg::OP_LOG0, bhs_pkg::OP_LOG4)));
            else if (r < 68)
                prog.insert(prog.size(), RAW_OPS[$urandom_range(0, 2)]);
            else if (r < 78)
            begin
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 2);
                prog.insert(prog.size(), bhs_pkg::OP_PUSH_BASE + 8'(n));
                for (int k = 0; k < n; k++)
                    prog.insert(prog.size(), 8'($urandom));
            end
            else
                prog.insert(prog.size(), 8'($urandom));
        end
        if ($urandom_range(0, 5) == 0 && prog.size() > 1)
        begin
            cut = $urandom_range(1, prog.size());
            while (prog.size() > cut)
                prog.delete(prog.size() - 1);
        end
        queue_program_bytes(prog);
    endtask

    task automatic queue_random_bytes(input int count);
        int goal;
        int r;
        goal = planned_bytes + count;
        while (planned_bytes < goal)
        begin
            r = $urandom_range(0, 9);
            if (r < 7)
                queue_random_program($urandom_range(1, 30));
            else if (r < 9)
                queue_random_program($urandom_range(31, 120));
            else
                queue_random_program($urandom_range(121, 400));
        end
    endtask

    // Wait until every queued byte is taken and every report has come back.
    task automatic drain();
        while (program_bytes_q.size() != 0 || byte_ch.valid || expected_reports_q.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic load_limits(input logic [15:0] costly_max, input logic [15:0] jumps_max,
                               input logic [15:0] ratio_word);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= bhs_pkg::CFG_EXPENSIVE_LIMIT;
        cfg_data <= costly_max;
        @(posedge clk);
        cfg_index <= bhs_pkg::CFG_JUMP_LIMIT;
        cfg_data <= jumps_max;
        @(posedge clk);
        cfg_index <= bhs_pkg::CFG_RATIO_DIVISOR;
        cfg_data <= ratio_word;
        @(posedge clk);
        cfg_we <= 1'b0;
        expensive_lim = costly_max;
        jump_lim = jumps_max;
        ratio_div = ratio_word[7:0];
    endtask

    // Run limit, far above the slowest correct run.
    initial
    begin
        #2000000;
        $display("bytecode_hazard_scanner verification failed");
        $finish;
    end

    initial
    begin
        logic [7:0] prog[$];
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        expensive_lim = bhs_pkg::EXPENSIVE_LIMIT_RST;
        jump_lim = bhs_pkg::JUMP_LIMIT_RST;
        ratio_div = bhs_pkg::RATIO_DIVISOR_RST;
        start_program();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed programs: single-byte patterns, call then store inside and across
        // a code block, a loop with and without gas, a large target, a cut-off push.
        prog = '{bhs_pkg::OP_SELFDESTRUCT};
        queue_program_bytes(prog);
        prog = '{bhs_pkg::OP_CALL, bhs_pkg::OP_SSTORE};
        queue_program_bytes(prog);
        prog = '{bhs_pkg::OP_DELEGATECALL, bhs_pkg::OP_JUMPDEST, bhs_pkg::OP_SSTORE};
        queue_program_bytes(prog);
        prog = '{bhs_pkg::OP_ORIGIN, bhs_pkg::OP_JUMP};
        queue_program_bytes(prog);
        prog = '{bhs_pkg::OP_JUMPDEST, bhs_pkg::OP_GAS, bhs_pkg::OP_PUSH1, 8'h00,
                 bhs_pkg::OP_JUMP};
        queue_program_bytes(prog);
        prog = '{bhs_pkg::OP_JUMPDEST, bhs_pkg::OP_PUSH1, 8'h00, bhs_pkg::OP_JUMPI};
        queue_program_bytes(prog);
        prog = '{bhs_pkg::OP_PUSH1 + 8'd1, 8'h80, 8'h00, bhs_pkg::OP_JUMP};
        queue_program_bytes(prog);
        prog = '{bhs_pkg::OP_PUSH1 + 8'd1, 8'h00};
        queue_program_bytes(prog);
        drain();

        // Random programs under reset limits, then the extremes of each limit.
        queue_random_bytes(250);
        drain();
        load_limits(16'd0, 16'd0, 16'd1);
        queue_random_bytes(200);
        drain();
        load_limits(16'hffff, 16'hffff, 16'h00ff);
        queue_random_bytes(200);
        drain();

        // A zero divisor turns the ratio test off.
        load_limits(16'd3, 16'd2, 16'h0000);
        queue_random_bytes(150);
        drain();

        // Report side holds off while short programs keep arriving back to back.
        load_limits(16'($urandom_range(0, 20)), 16'($urandom_range(0, 8)),
                    16'($urandom_range(1, 20)));
        gap_cap = 0;
        holds_asked++;
        for (int k = 0; k < 40; k++)
            queue_random_program($urandom_range(1, 3));
        drain();

        // Random limits: a stretch with no idling, then idling on both sides.
        stall_cap = 0;
        load_limits(16'($urandom), 16'($urandom_range(0, 30)),
                    {8'($urandom), 8'($urandom_range(1, 255))});
        queue_random_bytes(150);
        drain();
        gap_cap = 11;
        stall_cap = 11;
        load_limits(16'($urandom_range(0, 60)), 16'($urandom_range(0, 10)),
                    16'($urandom_range(1, 255)));
        queue_random_bytes(150);
        drain();

        if (errors == 0)
            $display("bytecode_hazard_scanner verification clean");
        else
            $display("bytecode_hazard_scanner verification failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
hw/rtl/bhs_pkg.sv
hw/rtl/bhs_if.sv
hw/rtl/bhs_jd_map.sv
hw/rtl/bhs_report.sv
hw/rtl/bytecode_hazard_scanner.sv
verif/bytecode_hazard_scanner_tb.sv
